[src/fbln_pkg.sv]
// Package for the fused bias/skip layer-norm block.
// Shared types, field widths and register codes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fbln_pkg;

    // element width and the width of x = value + bias + skip
    localparam int DATA_W     = 16;
    localparam int XW         = DATA_W + 2;
    localparam int LEN_W      = 7;
    localparam int EPS_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int NW         = 32;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACT_MODE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HAS_SKIP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HAS_GAMMA  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HAS_BETA   = 3'd5;

    // activation codes
    localparam logic ACT_NONE = 1'b0;
    localparam logic ACT_RELU = 1'b1;

    // limits
    localparam logic [NW-1:0] N_LIMIT = 32'h7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] DW_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DW_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] bias;
        logic signed [DATA_W-1:0] skip;
        logic signed [DATA_W-1:0] gamma;
        logic signed [DATA_W-1:0] beta;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result;
        logic                     last;
    } out_item_t;

    typedef struct packed {
        logic [LEN_W-1:0] row_length;
        logic [EPS_W-1:0] epsilon;
        logic             act_mode;
        logic             has_skip;
        logic             has_gamma;
        logic             has_beta;
    } cfg_t;

endpackage

`default_nettype wire

[src/fbln_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fbln_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[src/fbln_div.sv]
// Radix-2 restoring divider for unsigned operands, one quotient bit a cycle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fbln_div #(
    parameter int W = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] dividend,
    input  wire logic [W-1:0] divisor,
    output logic              done,
    output logic      [W-1:0] quotient
);

    localparam int CNW = $clog2(W + 1);

    logic           busy_reg;
    logic           done_reg;
    logic [CNW-1:0] cnt_reg;
    logic [W-1:0]   rem_reg;
    logic [W-1:0]   quo_reg;
    logic [W-1:0]   dvs_reg;
    logic [W:0]     trial;
    logic           ge;

    // trial subtraction
    always_comb
    begin
        trial = {rem_reg, quo_reg[W-1]};
        ge    = (trial >= {1'b0, dvs_reg});
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNW'(1);
            if (cnt_reg == CNW'(W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? W'(trial - {1'b0, dvs_reg}) : trial[W-1:0];
            quo_reg <= {quo_reg[W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[src/fbln_front.sv]
// Front end: forms x per element, stores the row and keeps the row sums.
// Depends on fbln_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbln_front import fbln_pkg::*; #(
    parameter int ROW_MAX = 64,
    localparam int CW    = $clog2(ROW_MAX + 1),
    localparam int AW    = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1,
    localparam int SW    = XW + CW,
    localparam int SQW   = 2 * XW + CW,
    localparam int MEM_W = XW + 2 * DATA_W
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  accept,
    input  wire in_item_t              elem,
    input  wire cfg_t                  cfg,
    output logic                       mem_we,
    output logic [AW:0]                mem_waddr,
    output logic [MEM_W-1:0]           mem_wdata,
    output logic                       row_push,
    output logic [CW-1:0]              row_cnt,
    output logic signed [SW-1:0]       row_sum,
    output logic [SQW-1:0]             row_sq,
    output logic                       row_bank
);

    logic [CW-1:0]        cnt_reg;
    logic signed [SW-1:0] sum_reg;
    logic [SQW-1:0]       sq_reg;
    logic                 bank_reg;

    logic signed [XW-1:0] x;
    logic [XW-1:0]        ax;
    logic [2*XW-1:0]      sq;
    logic [LEN_W-1:0]     len;
    logic [CW-1:0]        cnt_next;
    logic                 row_done;

    // x, its square and the row end test
    always_comb
    begin
        x = XW'(elem.value) + XW'(elem.bias) + (cfg.has_skip ? XW'(elem.skip) : '0);
        ax = x[XW-1] ? XW'(-x) : XW'(x);
        sq = ax * ax;
        if (cfg.row_length == '0)
        begin
            len = LEN_W'(1);
        end
        else if (cfg.row_length > LEN_W'(ROW_MAX))
        begin
            len = LEN_W'(ROW_MAX);
        end
        else
        begin
            len = cfg.row_length;
        end
        cnt_next = cnt_reg + CW'(1);
        row_done = (LEN_W'(cnt_next) >= len);
    end

    // row store write
    assign mem_we    = accept;
    assign mem_waddr = {bank_reg, cnt_reg[AW-1:0]};
    assign mem_wdata = {x, elem.gamma, elem.beta};

    // finished row goes to the queue
    assign row_push = accept & row_done;
    assign row_cnt  = cnt_next;
    assign row_sum  = sum_reg + SW'(x);
    assign row_sq   = sq_reg + SQW'(sq);
    assign row_bank = bank_reg;

    // running sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            sum_reg  <= '0;
            sq_reg   <= '0;
            bank_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (row_done)
            begin
                cnt_reg  <= '0;
                sum_reg  <= '0;
                sq_reg   <= '0;
                bank_reg <= ~bank_reg;
            end
            else
            begin
                cnt_reg <= cnt_next;
                sum_reg <= row_sum;
                sq_reg  <= row_sq;
            end
        end
    end

endmodule

`default_nettype wire

[src/fbln_back.sv]
// Back end: row statistics, integer root, and per element normalise/affine.
// Depends on fbln_pkg and fbln_div.
`timescale 1ns / 1ps
`default_nettype none

module fbln_back import fbln_pkg::*; #(
    parameter int ROW_MAX = 64,
    localparam int CW    = $clog2(ROW_MAX + 1),
    localparam int AW    = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1,
    localparam int SW    = XW + CW,
    localparam int SQW   = 2 * XW + CW,
    localparam int MEM_W = XW + 2 * DATA_W
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cfg_t                 cfg,
    input  wire logic                 row_valid,
    input  wire logic [CW-1:0]        row_cnt,
    input  wire logic signed [SW-1:0] row_sum,
    input  wire logic [SQW-1:0]       row_sq,
    input  wire logic                 row_bank,
    output logic                      row_pop,
    output logic                      mem_re,
    output logic [AW:0]               mem_raddr,
    input  wire logic [MEM_W-1:0]     mem_rdata,
    output logic                      out_valid,
    output out_item_t                 out_item,
    input  wire logic                 out_pop
);

    localparam int DIVW  = (SQW > XW + 17) ? SQW : XW + 17;
    localparam int VARW  = SQW + 1;
    localparam int VW    = ((VARW + 16 + 1) / 2) * 2;
    localparam int RTW   = VW / 2;
    localparam int RMW   = RTW + 2;
    localparam int STW   = $clog2(RTW + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MEAN,
        S_SQ,
        S_ROOT,
        S_READ,
        S_DIFF,
        S_DIV,
        S_SCALE,
        S_FIN
    } state_t;

    state_t               state_reg;
    logic [CW-1:0]        cnt_reg;
    logic [CW-1:0]        idx_reg;
    logic                 bank_reg;
    logic                 sum_neg_reg;
    logic [SQW-1:0]       sq_reg;
    logic signed [XW-1:0] mean_reg;
    logic [XW-1:0]        mean_mag_reg;
    logic [2*XW-1:0]      m2_reg;
    logic [VW-1:0]        rad_reg;
    logic [RMW-1:0]       rem_reg;
    logic [RTW-1:0]       root_reg;
    logic [STW-1:0]       step_reg;
    logic                 d_neg_reg;
    logic signed [NW-1:0] n_reg;
    logic signed [47:0]   prod_reg;
    logic                 out_valid_reg;
    out_item_t            out_item_reg;

    // divider
    logic            div_start;
    logic [DIVW-1:0] div_dividend;
    logic [DIVW-1:0] div_divisor;
    logic            div_done;
    logic [DIVW-1:0] div_quot;

    // combinational helpers
    logic [SW-1:0]        sum_mag;
    logic [VARW-1:0]      var_w;
    logic [RMW-1:0]       rem2;
    logic [RMW-1:0]       trial;
    logic signed [XW-1:0] x_rd;
    logic signed [XW:0]   d;
    logic [XW-1:0]        d_mag;
    logic [NW-1:0]        qc;
    logic signed [39:0]   scaled;
    logic signed [40:0]   biased;
    logic signed [DATA_W-1:0] res;
    logic                 load;
    logic                 is_last;

    fbln_div #(
        .W (DIVW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // arithmetic around the sequencer
    always_comb
    begin
        sum_mag = row_sum[SW-1] ? SW'(-row_sum) : SW'(row_sum);
        if (div_quot[SQW-1:0] >= SQW'(m2_reg))
        begin
            var_w = VARW'(div_quot[SQW-1:0] - SQW'(m2_reg)) + VARW'(cfg.epsilon);
        end
        else
        begin
            var_w = VARW'(cfg.epsilon);
        end
        rem2  = {rem_reg[RMW-3:0], rad_reg[VW-1 -: 2]};
        trial = {root_reg, 2'b01};
        x_rd  = mem_rdata[MEM_W-1 -: XW];
        d     = (XW+1)'(x_rd) - (XW+1)'(mean_reg);
        d_mag = d[XW] ? XW'(-d) : XW'(d);
        qc    = (div_quot > DIVW'(N_LIMIT)) ? N_LIMIT : div_quot[NW-1:0];

        // gamma scale with truncation toward zero
        if (cfg.has_gamma)
        begin
            scaled = prod_reg[47] ? 40'((prod_reg + 48'sd255) >>> 8) : 40'(prod_reg >>> 8);
        end
        else
        begin
            scaled = 40'(n_reg);
        end
        biased = 41'(scaled) + (cfg.has_beta ? 41'($signed(mem_rdata[DATA_W-1:0])) : '0);
        if (cfg.act_mode == ACT_RELU && biased < 0)
        begin
            biased = '0;
        end
        if (biased > 41'(DW_MAX))
        begin
            res = DW_MAX;
        end
        else if (biased < 41'(DW_MIN))
        begin
            res = DW_MIN;
        end
        else
        begin
            res = biased[DATA_W-1:0];
        end

        load    = (state_reg == S_FIN) && (!out_valid_reg || out_pop);
        is_last = ((idx_reg + CW'(1)) == cnt_reg);
    end

    // divider operand selection and store read
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = DIVW'(cnt_reg);
        mem_re       = 1'b0;
        mem_raddr    = {bank_reg, idx_reg[AW-1:0]};
        row_pop      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                div_start    = row_valid;
                div_dividend = DIVW'(sum_mag);
                div_divisor  = DIVW'(row_cnt);
            end
            S_MEAN:
            begin
                div_start    = div_done;
                div_dividend = DIVW'(sq_reg);
            end
            S_READ:
            begin
                mem_re = 1'b1;
            end
            S_DIFF:
            begin
                div_start    = (root_reg != '0);
                div_dividend = DIVW'({d_mag, 16'h0});
                div_divisor  = DIVW'(root_reg);
            end
            S_FIN:
            begin
                row_pop = load && is_last;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    // sequencer with registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            bank_reg      <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            if (out_pop && !load)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                // take a finished row, start on the mean
                S_IDLE:
                begin
                    if (row_valid)
                    begin
                        cnt_reg     <= row_cnt;
                        bank_reg    <= row_bank;
                        sum_neg_reg <= row_sum[SW-1];
                        sq_reg      <= row_sq;
                        state_reg   <= S_MEAN;
                    end
                end
                // mean done, start on the mean of the squares
                S_MEAN:
                begin
                    if (div_done)
                    begin
                        mean_mag_reg <= XW'(div_quot);
                        mean_reg     <= sum_neg_reg ? -XW'(div_quot) : XW'(div_quot);
                        state_reg    <= S_SQ;
                    end
                end
                // variance plus epsilon, ready the root
                S_SQ:
                begin
                    if (div_done)
                    begin
                        rad_reg   <= VW'({var_w, 16'h0});
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        step_reg  <= '0;
                        state_reg <= S_ROOT;
                    end
                end
                // one root bit a cycle
                S_ROOT:
                begin
                    rad_reg <= rad_reg << 2;
                    if (rem2 >= trial)
                    begin
                        rem_reg  <= rem2 - trial;
                        root_reg <= {root_reg[RTW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem2;
                        root_reg <= {root_reg[RTW-2:0], 1'b0};
                    end
                    step_reg <= step_reg + STW'(1);
                    if (step_reg == STW'(RTW - 1))
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_DIFF;
                end
                // zero root gives zero before the affine step
                S_DIFF:
                begin
                    d_neg_reg <= d[XW];
                    if (root_reg == '0)
                    begin
                        n_reg     <= '0;
                        state_reg <= S_SCALE;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        n_reg     <= d_neg_reg ? -$signed(qc) : $signed(qc);
                        state_reg <= S_SCALE;
                    end
                end
                S_SCALE:
                begin
                    prod_reg  <= 48'(n_reg) * 48'($signed(mem_rdata[2*DATA_W-1:DATA_W]));
                    state_reg <= S_FIN;
                end
                // hand the element to the output register
                S_FIN:
                begin
                    if (load)
                    begin
                        out_valid_reg       <= 1'b1;
                        out_item_reg.result <= res;
                        out_item_reg.last   <= is_last;
                        if (is_last)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + CW'(1);
                            state_reg <= S_READ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // mean square, recomputed every cycle from the held magnitude
    always_ff @(posedge clk)
    begin
        m2_reg <= mean_mag_reg * mean_mag_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

[src/fused_bias_skip_layer_norm.sv]
// Top level of the fused bias/skip layer-norm block: registers, row queue,
// front end, back end and row store. Depends on fbln_pkg, fbln_front,
// fbln_back and fbln_ram.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+-----------------------------------
//  elem      | push / full             | in_item_t  value bias skip gamma beta
//  norm      | empty / pop             | out_item_t result last
//  cfg       | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// Elements load at one per cycle, while full is low, into a two-bank row
// store; a finished row goes to a two-entry queue and the back end emits it.
// Per row the back end runs two serial divides and a bit-serial root, then
// one divide per element (none when the root is zero) on the shared one-bit
// divider.
// full rises while two rows wait; a stalled pop holds the back end.
// Reset clears control only; the row store needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module fused_bias_skip_layer_norm import fbln_pkg::*; #(
    parameter int ROW_MAX = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire in_item_t              elem,
    output logic                       empty,
    input  wire logic                  pop,
    output out_item_t                  norm,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW    = $clog2(ROW_MAX + 1);
    localparam int AW    = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
    localparam int SW    = XW + CW;
    localparam int SQW   = 2 * XW + CW;
    localparam int MEM_W = XW + 2 * DATA_W;
    localparam int DEPTH = 2 * (2 ** AW);

    cfg_t cfg_reg;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_length <= LEN_W'(64);
            cfg_reg.epsilon    <= EPS_W'(1);
            cfg_reg.act_mode   <= ACT_NONE;
            cfg_reg.has_skip   <= 1'b0;
            cfg_reg.has_gamma  <= 1'b1;
            cfg_reg.has_beta   <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ROW_LENGTH: cfg_reg.row_length <= cfg_data[LEN_W-1:0];
                CFG_EPSILON:    cfg_reg.epsilon    <= cfg_data[EPS_W-1:0];
                CFG_ACT_MODE:   cfg_reg.act_mode   <= cfg_data[0];
                CFG_HAS_SKIP:   cfg_reg.has_skip   <= cfg_data[0];
                CFG_HAS_GAMMA:  cfg_reg.has_gamma  <= cfg_data[0];
                CFG_HAS_BETA:   cfg_reg.has_beta   <= cfg_data[0];
                default:        cfg_reg.has_beta   <= cfg_reg.has_beta;
            endcase
        end
    end

    // front end
    logic                 accept;
    logic                 mem_we;
    logic [AW:0]          mem_waddr;
    logic [MEM_W-1:0]     mem_wdata;
    logic                 f_push;
    logic [CW-1:0]        f_cnt;
    logic signed [SW-1:0] f_sum;
    logic [SQW-1:0]       f_sq;
    logic                 f_bank;

    assign accept = push & ~full;

    fbln_front #(
        .ROW_MAX (ROW_MAX)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .elem      (elem),
        .cfg       (cfg_reg),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .row_push  (f_push),
        .row_cnt   (f_cnt),
        .row_sum   (f_sum),
        .row_sq    (f_sq),
        .row_bank  (f_bank)
    );

    // two-entry row queue between front and back
    logic [CW-1:0]        q_cnt_reg  [2];
    logic signed [SW-1:0] q_sum_reg  [2];
    logic [SQW-1:0]       q_sq_reg   [2];
    logic                 q_bank_reg [2];
    logic [1:0]           q_fill_reg;
    logic                 q_wr_reg;
    logic                 q_rd_reg;
    logic                 b_pop;

    assign full = (q_fill_reg == 2'd2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_fill_reg <= '0;
            q_wr_reg   <= 1'b0;
            q_rd_reg   <= 1'b0;
        end
        else
        begin
            if (f_push)
            begin
                q_wr_reg <= ~q_wr_reg;
            end
            if (b_pop)
            begin
                q_rd_reg <= ~q_rd_reg;
            end
            if (f_push && !b_pop)
            begin
                q_fill_reg <= q_fill_reg + 2'd1;
            end
            else if (!f_push && b_pop)
            begin
                q_fill_reg <= q_fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_push)
        begin
            q_cnt_reg[q_wr_reg]  <= f_cnt;
            q_sum_reg[q_wr_reg]  <= f_sum;
            q_sq_reg[q_wr_reg]   <= f_sq;
            q_bank_reg[q_wr_reg] <= f_bank;
        end
    end

    // row store, one bank per row in flight
    logic             mem_re;
    logic [AW:0]      mem_raddr;
    logic [MEM_W-1:0] mem_rdata;

    fbln_ram #(
        .WIDTH (MEM_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // back end
    logic out_valid;

    fbln_back #(
        .ROW_MAX (ROW_MAX)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .row_valid (q_fill_reg != 2'd0),
        .row_cnt   (q_cnt_reg[q_rd_reg]),
        .row_sum   (q_sum_reg[q_rd_reg]),
        .row_sq    (q_sq_reg[q_rd_reg]),
        .row_bank  (q_bank_reg[q_rd_reg]),
        .row_pop   (b_pop),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .out_valid (out_valid),
        .out_item  (norm),
        .out_pop   (pop & out_valid)
    );

    assign empty = ~out_valid;

endmodule

`default_nettype wire

[tb/fbln_checker.sv]
// Row normalisation predictor and result checker for fused_bias_skip_layer_norm.
// Watches the elem, norm and cfg channels; depends on fbln_pkg only.
`timescale 1ns / 1ps

module fbln_checker import fbln_pkg::*; #(
    parameter int ROW_MAX = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic                  full,
    input  in_item_t              elem,
    input  logic                  empty,
    input  logic                  pop,
    input  out_item_t             norm,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending,
    output int                    rows_seen,
    output int                    results_seen
);

    // register copy as seen through the cfg channel
    logic [LEN_W-1:0] row_len_q;
    logic [EPS_W-1:0] eps_q;
    logic             relu_q;
    logic             skip_q;
    logic             gamma_q;
    logic             beta_q;

    // row accumulation
    longint          x_row [ROW_MAX];
    longint          g_row [ROW_MAX];
    longint          b_row [ROW_MAX];
    int              held;
    longint          sum_x;
    longint unsigned sum_sq;

    out_item_t norm_fifo[$];

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned r;
        longint unsigned bitv;
        r    = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= r + bitv)
            begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
                r = r >> 1;
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    // fold one element into the row, emit the row when it is complete
    task automatic take_element(in_item_t e);
        longint          x;
        longint unsigned ax;
        int              len;
        longint          mean;
        longint unsigned sq_avg;
        longint unsigned m2;
        longint unsigned var_v;
        longint unsigned root;
        longint          n;
        out_item_t       o;
        x = longint'(e.value) + longint'(e.bias);
        if (skip_q)
            x = x + longint'(e.skip);
        len = (row_len_q == 0) ? 1 : (row_len_q > ROW_MAX) ? ROW_MAX : int'(row_len_q);
        if (held >= ROW_MAX)
            held = 0;
        x_row[held] = x;
        g_row[held] = longint'(e.gamma);
        b_row[held] = longint'(e.beta);
        held++;
        sum_x = sum_x + x;
        ax = (x < 0) ? longint'(-x) : x;
        sum_sq = sum_sq + ax * ax;
        if (held < len)
            return;
        mean   = sum_x / held;
        sq_avg = sum_sq / longint'(held);
        ax     = (mean < 0) ? longint'(-mean) : mean;
        m2     = ax * ax;
        var_v  = (sq_avg >= m2) ? sq_avg - m2 : 0;
        var_v  = var_v + eps_q;
        root   = int_root(var_v << 16);
        for (int i = 0; i < held; i++)
        begin
            n = 0;
            if (root != 0)
            begin
                n = ((x_row[i] - mean) * 65536) / longint'(root);
                if (n > longint'(N_LIMIT))
                    n = longint'(N_LIMIT);
                if (n < -longint'(N_LIMIT))
                    n = -longint'(N_LIMIT);
            end
            if (gamma_q)
                n = (n * g_row[i]) / 256;
            if (beta_q)
                n = n + b_row[i];
            if (relu_q == ACT_RELU && n < 0)
                n = 0;
            if (n > longint'(DW_MAX))
                n = longint'(DW_MAX);
            if (n < longint'(DW_MIN))
                n = longint'(DW_MIN);
            o.result = n[DATA_W-1:0];
            o.last   = (i + 1 == held);
            norm_fifo.push_back(o);
        end
        rows_seen++;
        held   = 0;
        sum_x  = 0;
        sum_sq = 0;
    endtask

    // monitor all three channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_len_q = 7'd64;
            eps_q     = 16'd1;
            relu_q    = ACT_NONE;
            skip_q    = 1'b0;
            gamma_q   = 1'b1;
            beta_q    = 1'b1;
            held      = 0;
            sum_x     = 0;
            sum_sq    = 0;
            norm_fifo.delete();
            errors       = 0;
            rows_seen    = 0;
            results_seen = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ROW_LENGTH: row_len_q = cfg_data[LEN_W-1:0];
                    CFG_EPSILON:    eps_q     = cfg_data[EPS_W-1:0];
                    CFG_ACT_MODE:   relu_q    = cfg_data[0];
                    CFG_HAS_SKIP:   skip_q    = cfg_data[0];
                    CFG_HAS_GAMMA:  gamma_q   = cfg_data[0];
                    CFG_HAS_BETA:   beta_q    = cfg_data[0];
                    default: ;
                endcase
            end
            // compare before predicting so a same-edge row cannot jump the queue
            if (pop && !empty)
            begin
                results_seen++;
                if (norm_fifo.size() == 0)
                begin
                    $error("unexpected transaction: result %0d last %0b",
                           norm.result, norm.last);
                    errors++;
                end
                else
                begin
                    out_item_t exp_o;
                    exp_o = norm_fifo.pop_front();
                    if (norm.result !== exp_o.result)
                    begin
                        $error("result: expected %0d actual %0d", exp_o.result, norm.result);
                        errors++;
                    end
                    if (norm.last !== exp_o.last)
                    begin
                        $error("last: expected %0b actual %0b", exp_o.last, norm.last);
                        errors++;
                    end
                end
            end
            if (push && !full)
                take_element(elem);
        end
        pending = norm_fifo.size();
    end

endmodule

[tb/tb.sv]
// Stimulus and verdict for fused_bias_skip_layer_norm.
// Depends on fbln_pkg, the block itself and fbln_checker.
`timescale 1ns / 1ps

module tb import fbln_pkg::*;;

    localparam int LIMIT  = 1500000;
    localparam int SETTLE = 20;
    localparam int TARGET = 250;

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    in_item_t              elem;
    logic                  empty;
    logic                  pop;
    out_item_t             norm;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int errors;
    int pending;
    int rows_seen;
    int results_seen;
    int sent;
    bit no_gaps;
    bit hold_off;

    fused_bias_skip_layer_norm u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .elem(elem),
        .empty(empty), .pop(pop), .norm(norm), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    fbln_checker u_chk (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .elem(elem),
        .empty(empty), .pop(pop), .norm(norm), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending), .rows_seen(rows_seen),
        .results_seen(results_seen)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        repeat (LIMIT) @(posedge clk);
        $display("Simulation FAILED");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: random stalls, plus the long hold-off when asked
    initial
    begin
        int stall;
        stall = 0;
        pop   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
                pop <= 1'b0;
            else if (stall > 0)
            begin
                pop <= 1'b0;
                stall--;
            end
            else
            begin
                pop   <= 1'b1;
                stall = gap_len();
            end
        end
    end

    task automatic send(in_item_t it);
        int g;
        @(negedge clk);
        push <= 1'b1;
        elem <= it;
        do
            @(posedge clk);
        while (full);
        sent++;
        g = gap_len();
        if (g > 0)
        begin
            @(negedge clk);
            push <= 1'b0;
            repeat (g - 1) @(negedge clk);
        end
    endtask

    task automatic push_done();
        @(negedge clk);
        push <= 1'b0;
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        push_done();
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic cfg_all(int len, int eps, bit relu, bit sk, bit gm, bit bt);
        cfg_write(CFG_ROW_LENGTH, CFG_DATA_W'(len));
        cfg_write(CFG_EPSILON, CFG_DATA_W'(eps));
        cfg_write(CFG_ACT_MODE, CFG_DATA_W'(relu ? ACT_RELU : ACT_NONE));
        cfg_write(CFG_HAS_SKIP, CFG_DATA_W'(sk));
        cfg_write(CFG_HAS_GAMMA, CFG_DATA_W'(gm));
        cfg_write(CFG_HAS_BETA, CFG_DATA_W'(bt));
    endtask

    function automatic in_item_t mk(int v, int b, int s, int g, int be);
        in_item_t it;
        it.value = v[DATA_W-1:0];
        it.bias  = b[DATA_W-1:0];
        it.skip  = s[DATA_W-1:0];
        it.gamma = g[DATA_W-1:0];
        it.beta  = be[DATA_W-1:0];
        return it;
    endfunction

    // random element: full range, small Q8.8 values, or copies of a base for flat rows
    function automatic in_item_t rand_item(int kind, in_item_t base);
        in_item_t it;
        it = in_item_t'((5 * DATA_W)'({$urandom, $urandom, $urandom}));
        if (kind == 1)
        begin
            it.value = DATA_W'($urandom_range(0, 1023) - 512);
            it.bias  = DATA_W'($urandom_range(0, 255) - 128);
            it.skip  = DATA_W'($urandom_range(0, 255) - 128);
            it.gamma = DATA_W'($urandom_range(0, 1023) - 512);
            it.beta  = DATA_W'($urandom_range(0, 511) - 256);
        end
        else if (kind == 2)
        begin
            it.value = base.value;
            it.bias  = base.bias;
            it.skip  = base.skip;
        end
        return it;
    endfunction

    initial
    begin
        int len;
        int eff;
        int cnt;
        int kind;
        int r;
        in_item_t base;
        rst_n     = 1'b0;
        push      = 1'b0;
        elem      = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ROW_LENGTH;
        cfg_data  = '0;
        no_gaps   = 1'b0;
        hold_off  = 1'b0;
        sent      = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // field extremes with every option on, then off
        cfg_all(4, 16'hFFFF, 1, 1, 1, 1);
        send(mk(32767, 32767, 32767, -32768, 32767));
        send(mk(-32768, -32768, -32768, 32767, -32768));
        send(mk(0, 0, 0, 32767, 0));
        send(mk(-1, 1, -1, -1, 1));
        settle();
        cfg_all(4, 0, 0, 0, 0, 0);
        send(mk(32767, 32767, 0, 0, 0));
        send(mk(-32768, -32768, 0, 0, 0));
        send(mk(32767, -32768, 0, 0, 0));
        send(mk(1, 0, 0, 0, 0));
        settle();

        // zero root: flat row with no epsilon
        cfg_all(3, 0, 0, 1, 1, 1);
        send(mk(256, 10, -10, 512, 100));
        send(mk(256, 10, -10, -512, -100));
        send(mk(256, 10, -10, 256, 32767));
        settle();

        // row length zero behaves as one
        cfg_write(CFG_ROW_LENGTH, 16'd0);
        send(mk(1000, 0, 0, 256, 0));
        send(mk(-1000, 5, 7, 256, 3));
        settle();

        // row length lowered after part of a row has arrived
        cfg_all(8, 1, 0, 0, 1, 1);
        for (int i = 0; i < 5; i++)
            send(rand_item(1, base));
        settle();
        cfg_write(CFG_ROW_LENGTH, 16'd3);
        cfg_write(CFG_HAS_SKIP, 16'd1);
        send(rand_item(1, base));
        settle();

        // long receiver hold-off with short rows so the row queue fills
        cfg_all(4, 1, 0, 0, 1, 1);
        fork
            begin
                hold_off = 1'b1;
                repeat (3000) @(posedge clk);
                hold_off = 1'b0;
            end
        join_none
        for (int i = 0; i < 20; i++)
            send(rand_item(1, base));
        settle();

        // random phases
        while (sent < TARGET)
        begin
            r = $urandom_range(0, 9);
            case (r)
                0:       len = 0;
                1:       len = $urandom_range(65, 127);
                2:       len = 64;
                3, 4:    len = 1 + $urandom_range(0, 2);
                default: len = $urandom_range(2, 12);
            endcase
            eff = (len == 0) ? 1 : (len > 64) ? 64 : len;
            r = $urandom_range(0, 3);
            cfg_all(len, (r == 0) ? 0 : (r == 1) ? 65535 : $urandom_range(0, 65535),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            no_gaps = ($urandom_range(0, 3) == 0);
            // mostly whole rows, sometimes a ragged tail
            cnt = eff * (1 + ((eff > 16) ? 0 : $urandom_range(0, 3)));
            if ($urandom_range(0, 5) == 0)
                cnt = cnt + $urandom_range(1, eff);
            kind = $urandom_range(0, 4);
            kind = (kind < 2) ? 0 : (kind < 4) ? 1 : 2;
            base = rand_item(0, base);
            for (int i = 0; i < cnt; i++)
                send(rand_item(kind, base));
            settle();
        end
        no_gaps = 1'b0;

        $display("covered %0d elements in %0d rows, %0d results checked",
                 sent, rows_seen, results_seen);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
